@@ rtl/core/periodic_state_model_query_core_assert.svh @@
// assertion macros for the periodic state model query core
`ifndef PERIODIC_STATE_MODEL_QUERY_CORE_ASSERT_SVH
`define PERIODIC_STATE_MODEL_QUERY_CORE_ASSERT_SVH
`ifndef SYNTH
`define PSMQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psmq check failed");
`define PSMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psmq check failed");
`else
`define PSMQ_ASSERT_NOW(label, ante, cons)
`define PSMQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/psmq_pkg.sv @@
// types, codes and cosine table function for the periodic state model query core
package psmq_pkg;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_ADD    = 2'd3;

  localparam logic [1:0] CFG_GAIN   = 2'd0;
  localparam logic [1:0] CFG_ORDER  = 2'd1;
  localparam logic [1:0] CFG_LENGTH = 2'd2;

  localparam int ACC_W  = 42;
  localparam int FRAC_W = 16;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [17:0] cos_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] frac;
  } div_res_t;

  function automatic logic [63:0] sub_floor(input logic [63:0] a, input logic [63:0] b);
    return (a > b) ? (a - b) : 64'd0;
  endfunction

  // quarter-wave cosine, horner polynomial in q30, rounded to q16
  function automatic logic [16:0] quarter_cos(input logic [63:0] p);
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] r;
    th = (p * HALF_PI_Q30) >> 16;
    x2 = (th * th) >> 30;
    t  = 64'd296;
    t  = sub_floor(64'd26631, (x2 * t) >> 30);
    t  = sub_floor(64'd1491308, (x2 * t) >> 30);
    t  = sub_floor(64'd44739243, (x2 * t) >> 30);
    t  = sub_floor(64'd536870912, (x2 * t) >> 30);
    t  = sub_floor(Q30_ONE, (x2 * t) >> 30);
    r  = (t + 64'd8192) >> 14;
    return r[16:0];
  endfunction

  function automatic cos_t cos_entry(input int k, input int bits);
    int          q;
    int          rr;
    logic [63:0] p;
    logic [17:0] v;
    q  = k >> (bits - 2);
    rr = k & ((1 << (bits - 2)) - 1);
    p  = 64'(rr << (18 - bits));
    case (q)
      0:       v = {1'b0, quarter_cos(p)};
      1:       v = -{1'b0, quarter_cos(64'd65536 - p)};
      2:       v = -{1'b0, quarter_cos(p)};
      default: v = {1'b0, quarter_cos(64'd65536 - p)};
    endcase
    return cos_t'(v);
  endfunction

endpackage

@@ rtl/core/psmq_divider.sv @@
// bit-serial restoring divider giving the 16-bit fraction of (dividend mod divisor)/divisor
module psmq_divider #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [DVD_W-1:0]      dividend,
  input  logic [DVS_W-1:0]      divisor,
  output psmq_pkg::div_res_t    res
);
  import psmq_pkg::*;

  localparam int STEPS = DVD_W + FRAC_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r;
  logic [FRAC_W-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic [DVS_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        dvd_r <= dividend;
        dvs_r <= divisor;
        rem_r <= '0;
        q_r   <= '0;
        cnt_r <= CNT_W'(STEPS);
      end else if (cnt_r != '0) begin
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
        // remainder stays below the divisor, so its top bit is always zero
        rem_r <= ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
        q_r   <= {q_r[FRAC_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.frac = q_r;

endmodule

@@ rtl/core/psmq_cos_rom.sv @@
// full-turn cosine rom with registered read
module psmq_cos_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic [TABLE_BITS-1:0] addr,
  output psmq_pkg::cos_t        data
);
  import psmq_pkg::*;

  localparam int ENTRIES = 1 << TABLE_BITS;

  cos_t rom_w [ENTRIES];
  cos_t data_r;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_rom
    localparam cos_t VAL = cos_entry(k, TABLE_BITS);
    assign rom_w[k] = VAL;
  end

  always_ff @(posedge clk) begin
    data_r <= rom_w[addr];
  end

  assign data = data_r;

endmodule

@@ rtl/core/periodic_state_model_query_core.sv @@
// periodic binary state model: component table, outlier store and query sequencer
// Usage:
//   Items enter on start with busy low; req_type picks load component, append
//   outlier, query or add sample. busy stays high until the item is done.
//   Each item gives one result on the out_ ports, shown for one cycle with
//   out_valid high; the receiver cannot stall, so results are never held.
//   Configuration (gain, order, initial length) goes through cfg_valid/cfg_ready,
//   always ready; the user must write it only while the block is idle (unchecked).
// Sequencing:
//   load and append go from start through S_RESP to a registered out_valid.
//   query and add run S_COMP_RD, S_MUL, S_DIV_GO, S_DIV_WAIT, S_COS_RD,
//   S_COS_MUL and S_ACC for each component index below the order, then S_FIN
//   and S_RESP; the bit-serial divider forming (t*freq mod L)/L dominates. A query
//   first scans outlier entries through the outlier memory read port (S_SCAN_RD,
//   S_SCAN_CMP), with an extra read state when every stored entry is passed.
//   A new item may start in the cycle its result is shown.
// Reset:
//   synchronous, rst_n low; clears the component valid bits, outlier count,
//   added sample count and registers (gain 0, order 0, length 1). The outlier
//   memory is not cleared; entries are read only below the count.
module periodic_state_model_query_core #(
  parameter int MAX_ORDER      = 16,
  parameter int MAX_OUTLIERS   = 256,
  parameter int COS_TABLE_BITS = 10,
  parameter int LENGTH_BITS    = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_comp_index,
  input  logic [15:0] in_comp_amplitude,
  input  logic [15:0] in_comp_phase,
  input  logic [23:0] in_comp_frequency,
  input  logic [23:0] in_outlier_position,
  input  logic [23:0] in_time_stamp,
  input  logic        in_sample_value,
  output logic        out_valid,
  output logic [16:0] out_estimate_level,
  output logic        out_state_bit,
  output logic        out_outlier_added,
  output logic        out_overflow,
  output logic [23:0] out_current_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import psmq_pkg::*;

  `include "periodic_state_model_query_core_assert.svh"

  localparam int LB    = LENGTH_BITS;
  localparam int TW    = (LB > 24) ? LB : 24;
  localparam int PW    = TW + 24;
  localparam int SUMW  = TW + 1;
  localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CW    = $clog2(MAX_ORDER + 1);
  localparam int OAW   = $clog2(MAX_OUTLIERS);
  localparam int CNTW  = $clog2(MAX_OUTLIERS + 1);
  localparam int ENT_W = 56;
  localparam logic [SUMW-1:0] LEN_MAX = SUMW'((64'd1 << LB) - 64'd1);
  localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(64'd1 << 32);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_COMP_RD  = 4'd3;
  localparam logic [3:0] S_MUL      = 4'd4;
  localparam logic [3:0] S_DIV_GO   = 4'd5;
  localparam logic [3:0] S_DIV_WAIT = 4'd6;
  localparam logic [3:0] S_COS_RD   = 4'd7;
  localparam logic [3:0] S_COS_MUL  = 4'd8;
  localparam logic [3:0] S_ACC      = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;
  localparam logic [3:0] S_RESP     = 4'd11;

  // configuration
  logic [15:0] gain_r;
  logic [4:0]  order_r;
  logic [23:0] init_len_r;

  // control
  logic [3:0]      state_r;
  logic [3:0]      state_nxt;
  logic [1:0]      req_r;
  logic            sample_r;
  logic [TW-1:0]   t_r;
  logic [LB-1:0]   len_r;
  logic [CW-1:0]   k_r;
  logic [CW-1:0]   n_r;
  logic [CNTW-1:0] scan_r;
  logic [CNTW-1:0] ocnt_r;
  logic [LB-1:0]   added_r;
  logic            out_valid_r;

  // datapath
  logic [ACC_W-1:0]   acc_r;
  logic [PW-1:0]      prod_r;
  logic signed [34:0] mp_r;
  logic [16:0]        est_r;
  logic               bit_r;
  logic               oadd_r;
  logic               ovf_r;
  logic [16:0]        out_est_r;
  logic               out_bit_r;
  logic               out_add_r;
  logic               out_ovf_r;
  logic [23:0]        out_len_r;

  // component table
  logic [ENT_W-1:0]     ctab [MAX_ORDER];
  logic [MAX_ORDER-1:0] cvalid_r;
  logic [ENT_W-1:0]     ctab_q_r;
  logic                 ctab_v_r;
  logic [ENT_W-1:0]     ent;
  logic [15:0]          ent_amp;
  logic [15:0]          ent_phase;
  logic [23:0]          ent_freq;

  // outlier store
  logic [TW-1:0]  omem [MAX_OUTLIERS];
  logic [TW-1:0]  ord_r;
  logic           owe;
  logic [OAW-1:0] owaddr;
  logic [TW-1:0]  owdata;

  logic [SUMW-1:0] len_sum;
  logic [LB-1:0]   eff_len;
  logic            accept;
  logic            load_ok;
  logic            room;
  div_res_t        div_res;
  cos_t            cos_q;
  logic [15:0]     turn;
  logic [16:0]     est_v;
  logic            pbit;
  int              n_int;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign room      = ocnt_r < CNTW'(MAX_OUTLIERS);
  assign load_ok   = int'(in_comp_index) < MAX_ORDER;

  // effective length: saturating sum, zero read as one
  always_comb begin
    len_sum = SUMW'(init_len_r) + SUMW'(added_r);
    if (len_sum > LEN_MAX) begin
      eff_len = LEN_MAX[LB-1:0];
    end else if (len_sum == '0) begin
      eff_len = LB'(1);
    end else begin
      eff_len = len_sum[LB-1:0];
    end
  end

  always_comb begin
    n_int = (int'(order_r) > MAX_ORDER) ? MAX_ORDER : int'(order_r);
  end

  assign ent       = ctab_v_r ? ctab_q_r : '0;
  assign ent_amp   = ent[55:40];
  assign ent_phase = ent[39:24];
  assign ent_freq  = ent[23:0];
  assign turn      = div_res.frac + ent_phase;

  always_comb begin
    if ($signed(acc_r) <= 0) begin
      est_v = 17'd0;
    end else if ($signed(acc_r) >= $signed(ACC_ONE)) begin
      est_v = 17'd65536;
    end else begin
      est_v = {1'b0, acc_r[31:16]};
    end
  end

  assign pbit = (est_v > 17'd32768) ^ ocnt_r[0];

  psmq_divider #(
    .DVD_W(PW),
    .DVS_W(LB)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (state_r == S_DIV_GO),
    .dividend(prod_r),
    .divisor (len_r),
    .res     (div_res)
  );

  psmq_cos_rom #(
    .TABLE_BITS(COS_TABLE_BITS)
  ) u_cos (
    .clk (clk),
    .addr(turn[15 -: COS_TABLE_BITS]),
    .data(cos_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_QUERY: state_nxt = S_SCAN_RD;
            REQ_ADD:   state_nxt = S_COMP_RD;
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_SCAN_RD:  state_nxt = (scan_r < ocnt_r) ? S_SCAN_CMP : S_COMP_RD;
      S_SCAN_CMP: state_nxt = (ord_r <= t_r) ? S_SCAN_RD : S_COMP_RD;
      S_COMP_RD:  state_nxt = (k_r < n_r) ? S_MUL : S_FIN;
      S_MUL:      state_nxt = S_DIV_GO;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: state_nxt = div_res.done ? S_COS_RD : S_DIV_WAIT;
      S_COS_RD:   state_nxt = S_COS_MUL;
      S_COS_MUL:  state_nxt = S_ACC;
      S_ACC:      state_nxt = S_COMP_RD;
      S_FIN:      state_nxt = S_RESP;
      S_RESP:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outlier store write: append at accept, add when the prediction misses
  always_comb begin
    owe    = 1'b0;
    owaddr = ocnt_r[OAW-1:0];
    owdata = TW'(in_outlier_position);
    if (accept && in_req_type == REQ_APPEND && room) begin
      owe = 1'b1;
    end else if (state_r == S_FIN && req_r == REQ_ADD && pbit != sample_r && room) begin
      owe    = 1'b1;
      owdata = TW'(len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (owe) begin
      omem[owaddr] <= owdata;
    end
    ord_r <= omem[scan_r[OAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept && in_req_type == REQ_LOAD && load_ok) begin
      ctab[IW'(in_comp_index)] <= {in_comp_amplitude, in_comp_phase, in_comp_frequency};
    end
    ctab_q_r <= ctab[k_r[IW-1:0]];
    ctab_v_r <= cvalid_r[k_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= '0;
      order_r     <= '0;
      init_len_r  <= 24'd1;
      cvalid_r    <= '0;
      ocnt_r      <= '0;
      added_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GAIN:   gain_r     <= cfg_data[15:0];
          CFG_ORDER:  order_r    <= cfg_data[4:0];
          CFG_LENGTH: init_len_r <= cfg_data;
          default:    ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r    <= in_req_type;
            sample_r <= in_sample_value;
            len_r    <= eff_len;
            t_r      <= (in_req_type == REQ_ADD) ? TW'(eff_len) : TW'(in_time_stamp);
            k_r      <= '0;
            n_r      <= CW'(n_int);
            scan_r   <= '0;
            acc_r    <= ACC_W'({gain_r, 16'd0});
            est_r    <= '0;
            bit_r    <= 1'b0;
            oadd_r   <= 1'b0;
            ovf_r    <= 1'b0;
            if (in_req_type == REQ_LOAD && load_ok) begin
              cvalid_r[IW'(in_comp_index)] <= 1'b1;
            end
            if (in_req_type == REQ_APPEND) begin
              if (room) begin
                ocnt_r <= ocnt_r + 1'b1;
              end else begin
                ovf_r <= 1'b1;
              end
            end
          end
        end
        S_SCAN_CMP: begin
          if (ord_r <= t_r) begin
            scan_r <= scan_r + 1'b1;
          end
        end
        S_MUL: begin
          prod_r <= PW'(t_r) * PW'(ent_freq);
        end
        S_COS_MUL: begin
          mp_r <= $signed({1'b0, ent_amp}) * cos_q;
        end
        S_ACC: begin
          // term is signed, so it is sign-extended into the accumulator
          acc_r <= acc_r + ACC_W'($signed({mp_r, 1'b0}));
          k_r   <= k_r + 1'b1;
        end
        S_FIN: begin
          est_r <= est_v;
          if (req_r == REQ_QUERY) begin
            bit_r <= (est_v >= 17'd32768) ^ scan_r[0];
          end else begin
            bit_r <= pbit;
            if (pbit != sample_r) begin
              if (room) begin
                ocnt_r <= ocnt_r + 1'b1;
                oadd_r <= 1'b1;
              end else begin
                ovf_r <= 1'b1;
              end
            end
            if (SUMW'(added_r) < LEN_MAX) begin
              added_r <= added_r + 1'b1;
            end
          end
        end
        S_RESP: begin
          out_valid_r <= 1'b1;
          out_est_r   <= est_r;
          out_bit_r   <= bit_r;
          out_add_r   <= oadd_r;
          out_ovf_r   <= ovf_r;
          out_len_r   <= 24'(TW'(eff_len));
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_estimate_level = out_est_r;
  assign out_state_bit      = out_bit_r;
  assign out_outlier_added  = out_add_r;
  assign out_overflow       = out_ovf_r;
  assign out_current_length = out_len_r;

  `PSMQ_ASSERT_NOW(a_result_when_idle, out_valid, !busy)
  `PSMQ_ASSERT_NEXT(a_start_makes_busy, start && !busy, busy)
  `PSMQ_ASSERT_NOW(a_add_or_drop, out_valid && out_outlier_added, !out_overflow)
  `PSMQ_ASSERT_NOW(a_count_bound, 1'b1, ocnt_r <= CNTW'(MAX_OUTLIERS))

endmodule
